// ===== rtl/nrsh_pkg.sv =====
// Shared types and defaults for the nearest ray/segment hit block.
// No dependencies; imported by every module of the block.
`default_nettype none
package nrsh_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int COORD_BITS_DEF   = 24;
  localparam int COUNT_W          = 9;
  localparam int SLOT_W           = 8;
  localparam int SLOT_LIMIT       = 256;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              ok;
    logic [SLOT_W-1:0] idx;
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/nrsh_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit for x and y.
// Depends on nrsh_pkg (tag_t).
`default_nettype none
module nrsh_div_cell import nrsh_pkg::*; #(
  parameter int MW = 50,
  parameter int Q  = 25
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tag_t          tag_in,
  input  wire logic [MW-1:0] den_in,
  input  wire logic [MW-1:0] rem_x_in,
  input  wire logic [MW-1:0] rem_y_in,
  input  wire logic [Q-1:0]  low_x_in,
  input  wire logic [Q-1:0]  low_y_in,
  output tag_t               tag_out,
  output logic      [MW-1:0] den_out,
  output logic      [MW-1:0] rem_x_out,
  output logic      [MW-1:0] rem_y_out,
  output logic      [Q-1:0]  low_x_out,
  output logic      [Q-1:0]  low_y_out
);

  logic [MW:0] tx, ty;
  logic        gx, gy;

  assign tx = {rem_x_in, low_x_in[Q-1]};
  assign ty = {rem_y_in, low_y_in[Q-1]};
  assign gx = tx >= {1'b0, den_in};
  assign gy = ty >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    den_out   <= den_in;
    rem_x_out <= gx ? MW'(tx - {1'b0, den_in}) : tx[MW-1:0];
    rem_y_out <= gy ? MW'(ty - {1'b0, den_in}) : ty[MW-1:0];
    low_x_out <= {low_x_in[Q-2:0], gx};
    low_y_out <= {low_y_in[Q-2:0], gy};
  end

endmodule
`default_nettype wire

// ===== rtl/nrsh_root.sv =====
// Bit-by-bit integer square root of the squared distance, saturated.
// Depends on nrsh_pkg.
`default_nettype none
module nrsh_root import nrsh_pkg::*; #(
  parameter int C = COORD_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2*C+1:0] value,
  output logic                done,
  output logic      [C-1:0]   root
);

  localparam int RW = C + 1;
  localparam int VW = 2 * C + 2;
  localparam int KW = $clog2(RW);

  logic [RW-1:0] r, cand;
  logic [VW-1:0] v, sq;
  logic [KW-1:0] k;
  logic          running;

  assign cand = r | (RW'(1) << k);
  assign sq   = VW'(cand) * VW'(cand);
  assign root = r[C] ? '1 : r[C-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && (k == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && k == '0) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      k <= KW'(C);
      v <= value;
    end else if (running) begin
      if (sq <= v) begin
        r <= cand;
      end
      k <= k - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nearest_ray_segment_hit_top.sv =====
// Nearest ray/segment hit: segment table, test pipeline, divider chain, root.
// Depends on nrsh_pkg, nrsh_div_cell and nrsh_root.
//
// A load (cmd 0) writes one table slot in the cycle it is taken and leaves
// busy low. A cast (cmd 1) holds busy until its result shows: the tested
// segments (none when the tested segment count is zero) stream one per
// cycle from the table through the test pipeline, each hit is
// divided in a chain of COORD_BITS+1 divider cells, and the winning squared
// distance goes through a square root that settles one bit per cycle. The
// result shows for one cycle with done high and must be taken then; the
// receiver cannot stall. A new command may be started in that same cycle.
`default_nettype none
module nearest_ray_segment_hit_top import nrsh_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cmd,
  input  wire logic        [SLOT_W-1:0]     slot,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         segment_count_we,
  input  wire logic        [COUNT_W-1:0]    segment_count,
  output logic                              done,
  output logic                              hit,
  output logic signed      [COORD_BITS-1:0] hit_x,
  output logic signed      [COORD_BITS-1:0] hit_y,
  output logic             [COORD_BITS-1:0] distance,
  output logic             [SLOT_W-1:0]     segment_index
);

  localparam int C   = COORD_BITS;
  localparam int LIM = MAX_SEGMENTS < SLOT_LIMIT ? MAX_SEGMENTS : SLOT_LIMIT;
  localparam int AW  = LIM > 1 ? $clog2(LIM) : 1;
  localparam int DW  = C + 1;
  localparam int MW  = 2 * C + 2;
  localparam int PW  = 2 * C + 3;
  localparam int Q   = C + 1;
  localparam int NW  = 3 * C + 3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_KICK  = 5'b01000,
    ST_ROOT  = 5'b10000
  } state_t;

  function automatic logic signed [DW-1:0] ext(input logic [C-1:0] v);
    return {v[C-1], v};
  endfunction

  function automatic logic span(input logic signed [PW-1:0] n,
                                input logic signed [PW-1:0] del);
    if (!del[PW-1]) begin
      return (n >= 0) && (n <= del);
    end
    return (n <= 0) && (n >= del);
  endfunction

  state_t              state;
  logic [COUNT_W-1:0]  count_reg, cnt, last_idx, lim;
  logic [4*C-1:0]      store [2**AW];
  logic [4*C-1:0]      mem_q;

  logic signed [C-1:0]  ox1, oy1;
  logic signed [DW-1:0] ra, rd;
  logic        [DW-1:0] ma, md;
  logic signed [DW-1:0] a_in, d_in;

  tag_t                 t1, t2, t3, t4, t5, t6, t7, f1, f2;
  logic signed [DW-1:0] sb, se, sc, sf;
  logic signed [MW-1:0] p_ae, p_db, p_ce, p_fb, p_cd, p_fa;
  logic signed [PW-1:0] delta, s_v, t_v;
  logic        [MW-1:0] as, ad, ad5, ad6;
  logic        [MW-1:0] pxl, pxh, pyl, pyh;
  logic        [NW-1:0] nx, ny;

  tag_t          ctag [Q+1];
  logic [MW-1:0] cden [Q+1];
  logic [MW-1:0] crx  [Q+1];
  logic [MW-1:0] cry  [Q+1];
  logic [Q-1:0]  clx  [Q+1];
  logic [Q-1:0]  cly  [Q+1];

  logic [DW-1:0]        fox, foy;
  logic [MW-1:0]        sqx, sqy, dsq, best;
  logic signed [C+1:0]  sum_x, sum_y;
  logic [C-1:0]         hx, hy, bx, by;
  logic [SLOT_W-1:0]    f2idx, bidx;
  logic                 found, take;
  logic                 root_start, root_done;
  logic [C-1:0]         root_val;

  assign busy = (state != ST_IDLE);
  assign lim  = (count_reg > COUNT_W'(LIM)) ? COUNT_W'(LIM) : count_reg;
  assign a_in = ext(end_x) - ext(start_x);
  assign d_in = ext(end_y) - ext(start_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
    end else if (segment_count_we) begin
      count_reg <= segment_count;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy && !cmd && int'(slot) < MAX_SEGMENTS) begin
      store[slot[AW-1:0]] <= {start_x, start_y, end_x, end_y};
    end
    mem_q <= store[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (start && !busy && cmd) begin
      ox1      <= start_x;
      oy1      <= start_y;
      ra       <= a_in;
      rd       <= d_in;
      ma       <= a_in[DW-1] ? DW'(-a_in) : a_in;
      md       <= d_in[DW-1] ? DW'(-d_in) : d_in;
      last_idx <= lim - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      t1    <= '0;
      found <= 1'b0;
    end else begin
      t1 <= (state == ST_SCAN) ?
            tag_t'{valid: 1'b1, last: (cnt == last_idx), ok: 1'b0, idx: cnt[SLOT_W-1:0]} :
            tag_t'('0);
      if (state == ST_IDLE && start && cmd) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (start && cmd) begin
            cnt   <= '0;
            state <= (lim == '0) ? ST_KICK : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == last_idx) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (f2.valid && f2.last) begin
            state <= ST_KICK;
          end
        end
        ST_KICK: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
      t6 <= '0;
      t7 <= '0;
      f1 <= '0;
      f2 <= '0;
    end else begin
      t2    <= t1;
      t3    <= t2;
      t4    <= t3;
      t5    <= tag_t'{valid: t4.valid,
                      last:  t4.last,
                      ok:    t4.valid && (delta != '0) && span(s_v, delta) &&
                             span(t_v, delta),
                      idx:   t4.idx};
      t6    <= t5;
      t7    <= t6;
      f1    <= ctag[Q];
      f2    <= f1;
    end
  end

  always_ff @(posedge clk) begin
    sb   <= ext(mem_q[2*C-1:C]) - ext(mem_q[4*C-1:3*C]);
    se   <= ext(mem_q[C-1:0]) - ext(mem_q[3*C-1:2*C]);
    sc   <= ext(mem_q[4*C-1:3*C]) - ext(ox1);
    sf   <= ext(mem_q[3*C-1:2*C]) - ext(oy1);
    p_ae <= ra * se;
    p_db <= rd * sb;
    p_ce <= sc * se;
    p_fb <= sf * sb;
    p_cd <= sc * rd;
    p_fa <= sf * ra;
    delta <= PW'(p_ae) - PW'(p_db);
    s_v   <= PW'(p_ce) - PW'(p_fb);
    t_v   <= PW'(p_cd) - PW'(p_fa);
    as    <= s_v[PW-1] ? MW'(-s_v) : MW'(s_v);
    ad    <= delta[PW-1] ? MW'(-delta) : MW'(delta);
    pxl   <= MW'(as[Q-1:0]) * MW'(ma);
    pxh   <= MW'(as[MW-1:Q]) * MW'(ma);
    pyl   <= MW'(as[Q-1:0]) * MW'(md);
    pyh   <= MW'(as[MW-1:Q]) * MW'(md);
    ad5   <= ad;
    nx    <= {pxh, Q'(0)} + NW'(pxl);
    ny    <= {pyh, Q'(0)} + NW'(pyl);
    ad6   <= ad5;
  end

  assign ctag[0] = t7;
  assign cden[0] = ad6;
  assign crx[0]  = nx[NW-1:Q];
  assign cry[0]  = ny[NW-1:Q];
  assign clx[0]  = nx[Q-1:0];
  assign cly[0]  = ny[Q-1:0];

  for (genvar g = 0; g < Q; g++) begin : g_div
    nrsh_div_cell #(
      .MW (MW),
      .Q  (Q)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tag_in    (ctag[g]),
      .den_in    (cden[g]),
      .rem_x_in  (crx[g]),
      .rem_y_in  (cry[g]),
      .low_x_in  (clx[g]),
      .low_y_in  (cly[g]),
      .tag_out   (ctag[g+1]),
      .den_out   (cden[g+1]),
      .rem_x_out (crx[g+1]),
      .rem_y_out (cry[g+1]),
      .low_x_out (clx[g+1]),
      .low_y_out (cly[g+1])
    );
  end

  assign sum_x = (C+2)'(ox1) + (ra[DW-1] ? -$signed({1'b0, fox}) : $signed({1'b0, fox}));
  assign sum_y = (C+2)'(oy1) + (rd[DW-1] ? -$signed({1'b0, foy}) : $signed({1'b0, foy}));

  always_ff @(posedge clk) begin
    fox   <= clx[Q] + DW'({crx[Q], 1'b0} >= {1'b0, cden[Q]});
    foy   <= cly[Q] + DW'({cry[Q], 1'b0} >= {1'b0, cden[Q]});
    sqx   <= MW'(fox) * MW'(fox);
    sqy   <= MW'(foy) * MW'(foy);
    hx    <= sum_x[C-1:0];
    hy    <= sum_y[C-1:0];
    f2idx <= f1.idx;
  end

  assign dsq  = sqx + sqy;
  assign take = f2.valid && f2.ok && (!found || dsq < best);

  always_ff @(posedge clk) begin
    if (take) begin
      best <= dsq;
      bidx <= f2idx;
      bx   <= hx;
      by   <= hy;
    end
  end

  assign root_start = (state == ST_KICK);

  nrsh_root #(
    .C (C)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (found ? best : MW'(0)),
    .done  (root_done),
    .root  (root_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= root_done;
    end
  end

  always_ff @(posedge clk) begin
    if (root_done) begin
      hit           <= found;
      hit_x         <= found ? bx : '0;
      hit_y         <= found ? by : '0;
      distance      <= found ? root_val : '0;
      segment_index <= found ? bidx : '0;
    end
  end

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (hit_x == '0 && hit_y == '0 && distance == '0 && segment_index == '0))
    else $error("miss result carries nonzero fields");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!t1.valid && !f2.valid))
    else $error("pipeline holds a segment while idle");
  a_tail_state: assert property (@(posedge clk) disable iff (rst)
    f2.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("segment left the pipeline outside a scan");
  a_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == ST_ROOT))
    else $error("root finished outside its phase");
`endif

endmodule
`default_nettype wire
